### sv/bitplane_life_cell_update_macros.svh
// Assertion macros for the bitplane life cell update block.
// Used by the checker; expects clk and rst_n in the scope of use.
`ifndef BITPLANE_LIFE_CELL_UPDATE_MACROS_SVH
`define BITPLANE_LIFE_CELL_UPDATE_MACROS_SVH

// same-cycle implication, disabled during reset
`define BLCU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define BLCU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/blcu_pkg.sv
// Package for the bitplane life cell update block: widths, codes, types.
// No dependencies; used by every RTL file of the block but blcu_frame_mem.
`default_nettype none
package blcu_pkg;

    localparam int DEF_MAX_ROWS   = 64;
    localparam int DEF_MAX_COLS   = 64;
    localparam int PIXEL_W        = 24;
    localparam int ROW_W          = 6;
    localparam int COL_W          = 6;
    localparam int SIZE_REG_W     = 7;
    localparam int RULE_W         = 18;
    localparam int CFG_DATA_W     = 18;
    localparam int CFG_IDX_W      = 2;
    localparam int CNT_W          = 4;
    localparam int SEL_W          = 5;
    localparam int SURVIVE_OFFSET = 9;

    localparam logic [SIZE_REG_W-1:0] RST_NUM_ROWS  = 7'd64;
    localparam logic [SIZE_REG_W-1:0] RST_NUM_COLS  = 7'd64;
    localparam logic [RULE_W-1:0]     RST_LIFE_RULE = 18'd6152;

    typedef enum logic [0:0] {
        OP_WRITE = 1'b0,
        OP_EVAL  = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_ROWS  = 2'd0,
        CFG_NUM_COLS  = 2'd1,
        CFG_LIFE_RULE = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef enum logic [3:0] {
        TAP_C,
        TAP_N,
        TAP_S,
        TAP_W,
        TAP_E,
        TAP_NW,
        TAP_NE,
        TAP_SW,
        TAP_SE
    } tap_t;

    typedef struct packed {
        logic clear;
        logic load_centre;
        logic add;
    } acc_ctrl_t;

endpackage
`default_nettype wire

### sv/blcu_cmd_if.sv
// Command channel: write or evaluate items with coordinates and pixel.
// Depends on blcu_pkg for field widths.
`default_nettype none
interface blcu_cmd_if;
    logic                          valid;
    logic                          ready;
    logic                          op;
    logic [blcu_pkg::ROW_W-1:0]    row;
    logic [blcu_pkg::COL_W-1:0]    col;
    logic [blcu_pkg::PIXEL_W-1:0]  pixel;

    modport source (output valid, output op, output row, output col, output pixel,
                    input ready);
    modport sink   (input valid, input op, input row, input col, input pixel,
                    output ready);
endinterface
`default_nettype wire

### sv/blcu_result_if.sv
// Result channel: next generation pixel and range flag.
// Depends on blcu_pkg for field widths.
`default_nettype none
interface blcu_result_if;
    logic                          valid;
    logic                          ready;
    logic [blcu_pkg::PIXEL_W-1:0]  next_pixel;
    logic                          out_of_range;

    modport source (output valid, output next_pixel, output out_of_range, input ready);
    modport sink   (input valid, input next_pixel, input out_of_range, output ready);
endinterface
`default_nettype wire

### sv/bitplane_life_cell_update.sv
// Top level of the bitplane life cell update block: config registers,
// output register, and the frame memory, sequencer and rule evaluator.
// Depends on blcu_pkg, blcu_cmd_if, blcu_result_if and the blcu_* modules.
//
//   channel   role    payload
//   cmd       sink    op, row, col, pixel
//   result    source  next_pixel, out_of_range
//   cfg       write   cfg_we, cfg_index, cfg_data
//
// A write does not leave the idle state. An in-range evaluate makes nine reads
// through the single frame memory port in READ, then passes DRAIN and FINISH.
// An out-of-range evaluate goes from idle straight to FINISH.
// Reset clears control and config only; frame contents are undefined until written.
// A finished result waits in the sequencer while the output register is full.
`default_nettype none
module bitplane_life_cell_update #(
    parameter int MAX_ROWS = blcu_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = blcu_pkg::DEF_MAX_COLS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    blcu_cmd_if.sink                            cmd,
    blcu_result_if.source                       result,
    input  wire logic                           cfg_we,
    input  wire logic [blcu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [blcu_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int RAW = $clog2(MAX_ROWS);
    localparam int CAW = $clog2(MAX_COLS);
    localparam int RSZ = ($clog2(MAX_ROWS + 1) > blcu_pkg::SIZE_REG_W) ?
                         $clog2(MAX_ROWS + 1) : blcu_pkg::SIZE_REG_W;
    localparam int CSZ = ($clog2(MAX_COLS + 1) > blcu_pkg::SIZE_REG_W) ?
                         $clog2(MAX_COLS + 1) : blcu_pkg::SIZE_REG_W;

    logic [blcu_pkg::SIZE_REG_W-1:0] num_rows_reg;
    logic [blcu_pkg::SIZE_REG_W-1:0] num_cols_reg;
    logic [blcu_pkg::RULE_W-1:0]     life_rule_reg;

    logic                          out_valid_reg;
    logic [blcu_pkg::PIXEL_W-1:0]  out_pixel_reg;
    logic                          out_oor_reg;

    logic [RSZ-1:0]                rows_used;
    logic [CSZ-1:0]                cols_used;
    logic                          out_free;
    logic                          mem_we;
    logic                          mem_re;
    logic [RAW+CAW-1:0]            mem_addr;
    logic [blcu_pkg::PIXEL_W-1:0]  mem_rdata;
    blcu_pkg::acc_ctrl_t           acc_ctrl;
    logic                          load;
    logic                          bad;
    logic [blcu_pkg::PIXEL_W-1:0]  eval_pixel;

    always_comb
    begin
        if (num_rows_reg == '0)
        begin
            rows_used = RSZ'(1);
        end
        else if (RSZ'(num_rows_reg) > RSZ'(MAX_ROWS))
        begin
            rows_used = RSZ'(MAX_ROWS);
        end
        else
        begin
            rows_used = RSZ'(num_rows_reg);
        end
        if (num_cols_reg == '0)
        begin
            cols_used = CSZ'(1);
        end
        else if (CSZ'(num_cols_reg) > CSZ'(MAX_COLS))
        begin
            cols_used = CSZ'(MAX_COLS);
        end
        else
        begin
            cols_used = CSZ'(num_cols_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg  <= blcu_pkg::RST_NUM_ROWS;
            num_cols_reg  <= blcu_pkg::RST_NUM_COLS;
            life_rule_reg <= blcu_pkg::RST_LIFE_RULE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                blcu_pkg::CFG_NUM_ROWS:  num_rows_reg  <= cfg_data[blcu_pkg::SIZE_REG_W-1:0];
                blcu_pkg::CFG_NUM_COLS:  num_cols_reg  <= cfg_data[blcu_pkg::SIZE_REG_W-1:0];
                blcu_pkg::CFG_LIFE_RULE: life_rule_reg <= cfg_data[blcu_pkg::RULE_W-1:0];
                default:                 ;
            endcase
        end
    end

    assign out_free = !out_valid_reg || result.ready;

    blcu_ctrl #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_op     (cmd.op),
        .in_row    (cmd.row),
        .in_col    (cmd.col),
        .rows_used (rows_used),
        .cols_used (cols_used),
        .out_free  (out_free),
        .in_ready  (cmd.ready),
        .mem_we    (mem_we),
        .mem_re    (mem_re),
        .mem_addr  (mem_addr),
        .acc_ctrl  (acc_ctrl),
        .load      (load),
        .bad       (bad)
    );

    blcu_frame_mem #(
        .AW (RAW + CAW),
        .DW (blcu_pkg::PIXEL_W)
    ) u_frame_mem (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (cmd.pixel),
        .rdata (mem_rdata)
    );

    blcu_rule_eval u_rule_eval (
        .clk        (clk),
        .acc_ctrl   (acc_ctrl),
        .rdata      (mem_rdata),
        .life_rule  (life_rule_reg),
        .next_pixel (eval_pixel)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_pixel_reg <= bad ? '0 : eval_pixel;
            out_oor_reg   <= bad;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.next_pixel   = out_pixel_reg;
    assign result.out_of_range = out_oor_reg;

endmodule
`default_nettype wire

### sv/blcu_frame_mem.sv
// Single-port synchronous frame memory, one access per cycle, registered read.
// No package dependency.
`default_nettype none
module blcu_frame_mem #(
    parameter int AW = 12,
    parameter int DW = 24
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic          re,
    input  wire logic [AW-1:0] addr,
    input  wire logic [DW-1:0] wdata,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

### sv/blcu_ctrl.sv
// Sequencer: accepts items, wraps neighbour coordinates, walks the nine reads.
// Depends on blcu_pkg.
`default_nettype none
module blcu_ctrl #(
    parameter int MAX_ROWS = blcu_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = blcu_pkg::DEF_MAX_COLS,
    localparam int RAW = $clog2(MAX_ROWS),
    localparam int CAW = $clog2(MAX_COLS),
    localparam int RSZ = ($clog2(MAX_ROWS + 1) > blcu_pkg::SIZE_REG_W) ?
                         $clog2(MAX_ROWS + 1) : blcu_pkg::SIZE_REG_W,
    localparam int CSZ = ($clog2(MAX_COLS + 1) > blcu_pkg::SIZE_REG_W) ?
                         $clog2(MAX_COLS + 1) : blcu_pkg::SIZE_REG_W
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    input  wire logic                       in_op,
    input  wire logic [blcu_pkg::ROW_W-1:0] in_row,
    input  wire logic [blcu_pkg::COL_W-1:0] in_col,
    input  wire logic [RSZ-1:0]             rows_used,
    input  wire logic [CSZ-1:0]             cols_used,
    input  wire logic                       out_free,
    output logic                            in_ready,
    output logic                            mem_we,
    output logic                            mem_re,
    output logic [RAW+CAW-1:0]              mem_addr,
    output blcu_pkg::acc_ctrl_t             acc_ctrl,
    output logic                            load,
    output logic                            bad
);

    blcu_pkg::state_t    state_reg, state_next;
    blcu_pkg::tap_t      tap_reg, tap_next;
    blcu_pkg::acc_ctrl_t acc_reg, acc_next;
    logic                bad_reg;
    logic [RAW-1:0]      r_reg, up_reg, down_reg;
    logic [CAW-1:0]      c_reg, left_reg, right_reg;

    logic           accept;
    logic           is_eval;
    logic           in_bad;
    logic [RSZ-1:0] row_ext, up_full, down_full;
    logic [CSZ-1:0] col_ext, left_full, right_full;
    logic [RAW-1:0] rd_row;
    logic [CAW-1:0] rd_col;

    assign row_ext = RSZ'(in_row);
    assign col_ext = CSZ'(in_col);
    assign in_bad  = (row_ext >= rows_used) || (col_ext >= cols_used);
    assign is_eval = (in_op == blcu_pkg::OP_EVAL);
    assign accept  = in_valid && (state_reg == blcu_pkg::ST_IDLE);

    assign up_full    = (row_ext == '0) ? rows_used - RSZ'(1) : row_ext - RSZ'(1);
    assign down_full  = (row_ext + RSZ'(1) >= rows_used) ? '0 : row_ext + RSZ'(1);
    assign left_full  = (col_ext == '0) ? cols_used - CSZ'(1) : col_ext - CSZ'(1);
    assign right_full = (col_ext + CSZ'(1) >= cols_used) ? '0 : col_ext + CSZ'(1);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            blcu_pkg::ST_IDLE:
            begin
                if (accept && is_eval)
                begin
                    state_next = in_bad ? blcu_pkg::ST_FINISH : blcu_pkg::ST_READ;
                end
            end
            blcu_pkg::ST_READ:
            begin
                if (tap_reg == blcu_pkg::TAP_SE)
                begin
                    state_next = blcu_pkg::ST_DRAIN;
                end
            end
            blcu_pkg::ST_DRAIN:
            begin
                state_next = blcu_pkg::ST_FINISH;
            end
            blcu_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = blcu_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = blcu_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rd_row = r_reg;
        rd_col = c_reg;
        unique case (tap_reg)
            blcu_pkg::TAP_C:  begin rd_row = r_reg;    rd_col = c_reg;     end
            blcu_pkg::TAP_N:  begin rd_row = up_reg;   rd_col = c_reg;     end
            blcu_pkg::TAP_S:  begin rd_row = down_reg; rd_col = c_reg;     end
            blcu_pkg::TAP_W:  begin rd_row = r_reg;    rd_col = left_reg;  end
            blcu_pkg::TAP_E:  begin rd_row = r_reg;    rd_col = right_reg; end
            blcu_pkg::TAP_NW: begin rd_row = up_reg;   rd_col = left_reg;  end
            blcu_pkg::TAP_NE: begin rd_row = up_reg;   rd_col = right_reg; end
            blcu_pkg::TAP_SW: begin rd_row = down_reg; rd_col = left_reg;  end
            blcu_pkg::TAP_SE: begin rd_row = down_reg; rd_col = right_reg; end
            default:          begin rd_row = r_reg;    rd_col = c_reg;     end
        endcase
    end

    always_comb
    begin
        in_ready = (state_reg == blcu_pkg::ST_IDLE);
        mem_we   = accept && !is_eval && !in_bad;
        mem_re   = (state_reg == blcu_pkg::ST_READ);
        load     = (state_reg == blcu_pkg::ST_FINISH) && out_free;
        if (state_reg == blcu_pkg::ST_IDLE)
        begin
            mem_addr = {RAW'(in_row), CAW'(in_col)};
        end
        else
        begin
            mem_addr = {rd_row, rd_col};
        end
        acc_next.clear       = accept && is_eval;
        acc_next.load_centre = mem_re && (tap_reg == blcu_pkg::TAP_C);
        acc_next.add         = mem_re && (tap_reg != blcu_pkg::TAP_C);
        if (accept)
        begin
            tap_next = blcu_pkg::TAP_C;
        end
        else if (mem_re && (tap_reg != blcu_pkg::TAP_SE))
        begin
            tap_next = blcu_pkg::tap_t'(tap_reg + 4'd1);
        end
        else
        begin
            tap_next = tap_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= blcu_pkg::ST_IDLE;
            tap_reg   <= blcu_pkg::TAP_C;
            acc_reg   <= '0;
            bad_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            tap_reg   <= tap_next;
            acc_reg   <= acc_next;
            if (accept)
            begin
                bad_reg <= in_bad;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            r_reg     <= RAW'(in_row);
            c_reg     <= CAW'(in_col);
            up_reg    <= up_full[RAW-1:0];
            down_reg  <= down_full[RAW-1:0];
            left_reg  <= left_full[CAW-1:0];
            right_reg <= right_full[CAW-1:0];
        end
    end

    assign acc_ctrl = acc_reg;
    assign bad      = bad_reg;

endmodule
`default_nettype wire

### sv/blcu_rule_eval.sv
// Per-bit neighbour counters and life rule lookup for all 24 bit planes.
// Depends on blcu_pkg.
`default_nettype none
module blcu_rule_eval (
    input  wire logic                               clk,
    input  wire blcu_pkg::acc_ctrl_t                acc_ctrl,
    input  wire logic [blcu_pkg::PIXEL_W-1:0]       rdata,
    input  wire logic [blcu_pkg::RULE_W-1:0]        life_rule,
    output logic      [blcu_pkg::PIXEL_W-1:0]       next_pixel
);

    logic [blcu_pkg::CNT_W-1:0]   count_reg [blcu_pkg::PIXEL_W];
    logic [blcu_pkg::PIXEL_W-1:0] centre_reg;
    logic [blcu_pkg::SEL_W-1:0]   sel [blcu_pkg::PIXEL_W];

    always_ff @(posedge clk)
    begin
        for (int b = 0; b < blcu_pkg::PIXEL_W; b++)
        begin
            if (acc_ctrl.clear)
            begin
                count_reg[b] <= '0;
            end
            else if (acc_ctrl.add)
            begin
                count_reg[b] <= count_reg[b] + blcu_pkg::CNT_W'(rdata[b]);
            end
        end
        if (acc_ctrl.load_centre)
        begin
            centre_reg <= rdata;
        end
    end

    always_comb
    begin
        for (int b = 0; b < blcu_pkg::PIXEL_W; b++)
        begin
            sel[b] = centre_reg[b] ?
                     blcu_pkg::SEL_W'(count_reg[b]) + blcu_pkg::SEL_W'(blcu_pkg::SURVIVE_OFFSET) :
                     blcu_pkg::SEL_W'(count_reg[b]);
            next_pixel[b] = life_rule[sel[b]];
        end
    end

endmodule
`default_nettype wire

### sv/blcu_checker.sv
// Port-level checker for bitplane_life_cell_update, bound to the top level.
// Depends on bitplane_life_cell_update_macros.svh and blcu_pkg.
`default_nettype none
`include "bitplane_life_cell_update_macros.svh"
module blcu_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          cmd_valid,
    input wire logic                          cmd_ready,
    input wire logic                          cmd_op,
    input wire logic                          result_valid,
    input wire logic                          result_ready,
    input wire logic [blcu_pkg::PIXEL_W-1:0]  result_next_pixel,
    input wire logic                          result_out_of_range
);

    `BLCU_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid, "result dropped while stalled")
    `BLCU_ASSERT_NOW(a_oor_zero, result_valid && result_out_of_range, result_next_pixel == '0, "out-of-range result carries nonzero pixel")
    `BLCU_ASSERT_NEXT(a_eval_busy, cmd_valid && cmd_ready && (cmd_op == blcu_pkg::OP_EVAL), !cmd_ready, "evaluate did not hold off the next item")
    `BLCU_ASSERT_NEXT(a_write_free, cmd_valid && cmd_ready && (cmd_op == blcu_pkg::OP_WRITE), cmd_ready, "write stalled the command channel")

endmodule

bind bitplane_life_cell_update blcu_checker u_blcu_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd_valid           (cmd.valid),
    .cmd_ready           (cmd.ready),
    .cmd_op              (cmd.op),
    .result_valid        (result.valid),
    .result_ready        (result.ready),
    .result_next_pixel   (result.next_pixel),
    .result_out_of_range (result.out_of_range)
);
`default_nettype wire

### dv/tb.sv
// Testbench for bitplane_life_cell_update: drives write and evaluate items, mirrors the
// frame store and config registers, and checks every next-generation pixel in order.
// Depends on blcu_pkg, blcu_cmd_if, blcu_result_if and the block's RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import blcu_pkg::*;

    localparam int MAX_ROWS     = DEF_MAX_ROWS;
    localparam int MAX_COLS     = DEF_MAX_COLS;
    localparam int CELLS        = MAX_ROWS * MAX_COLS;
    localparam int TAPS         = 9;
    localparam int CENTRE_TAP   = 4;
    localparam int DRAIN_CYCLES = 24;
    localparam int HOLD_CYCLES  = 400;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic [PIXEL_W-1:0] next_pixel;
        logic               out_of_range;
    } cell_result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    blcu_cmd_if    cmd_ch ();
    blcu_result_if res_ch ();

    bitplane_life_cell_update DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .result    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    logic [PIXEL_W-1:0]    frame_mirror [0:CELLS-1];
    bit                    cell_known   [0:CELLS-1];
    logic [SIZE_REG_W-1:0] rows_setting = RST_NUM_ROWS;
    logic [SIZE_REG_W-1:0] cols_setting = RST_NUM_COLS;
    logic [RULE_W-1:0]     rule_setting = RST_LIFE_RULE;
    cell_result_t          pending_results [$];
    int                    items_sent = 0;
    int                    errors = 0;
    bit                    idle_on = 1'b1;
    bit                    hold_req = 1'b0;

    always #5 clk = ~clk;

    function automatic int used_extent(input logic [SIZE_REG_W-1:0] v, input int lim);
        if (v == 0)
            return 1;
        if (v > lim)
            return lim;
        return v;
    endfunction

    function automatic bit in_range(input int r, input int c);
        return r < used_extent(rows_setting, MAX_ROWS) && c < used_extent(cols_setting, MAX_COLS);
    endfunction

    function automatic int tap_addr(input int r, input int c, input int k);
        int rows;
        int cols;
        rows = used_extent(rows_setting, MAX_ROWS);
        cols = used_extent(cols_setting, MAX_COLS);
        return ((r + k / 3 - 1 + rows) % rows) * MAX_COLS + (c + k % 3 - 1 + cols) % cols;
    endfunction

    function automatic logic [PIXEL_W-1:0] predict_next(input int r, input int c);
        logic [PIXEL_W-1:0] centre;
        logic [PIXEL_W-1:0] nxt;
        int cnt;
        int sel;
        centre = frame_mirror[tap_addr(r, c, CENTRE_TAP)];
        nxt = '0;
        for (int b = 0; b < PIXEL_W; b++)
        begin
            cnt = 0;
            for (int k = 0; k < TAPS; k++)
                if (k != CENTRE_TAP)
                    cnt += frame_mirror[tap_addr(r, c, k)][b];
            sel = centre[b] ? cnt + SURVIVE_OFFSET : cnt;
            nxt[b] = rule_setting[sel];
        end
        return nxt;
    endfunction

    task automatic send_item(input op_t op, input logic [ROW_W-1:0] r,
                             input logic [COL_W-1:0] c, input logic [PIXEL_W-1:0] pix);
        cell_result_t want;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.op    <= op;
        cmd_ch.row   <= r;
        cmd_ch.col   <= c;
        cmd_ch.pixel <= pix;
        do @(posedge clk); while (!cmd_ch.ready);
        items_sent++;
        if (op == OP_WRITE)
        begin
            if (in_range(r, c))
            begin
                frame_mirror[r * MAX_COLS + c] = pix;
                cell_known[r * MAX_COLS + c] = 1'b1;
            end
        end
        else
        begin
            if (in_range(r, c))
                want = '{next_pixel: predict_next(r, c), out_of_range: 1'b0};
            else
                want = '{next_pixel: '0, out_of_range: 1'b1};
            pending_results.push_back(want);
        end
    endtask

    // fill any unwritten cell of the neighbourhood, then evaluate
    task automatic eval_cell(input int r, input int c);
        int a;
        if (in_range(r, c))
            for (int k = 0; k < TAPS; k++)
            begin
                a = tap_addr(r, c, k);
                if (!cell_known[a])
                    send_item(OP_WRITE, a / MAX_COLS, a % MAX_COLS, $urandom);
            end
        send_item(OP_EVAL, r, c, $urandom);
    endtask

    task automatic settle();
        cmd_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_NUM_ROWS:  rows_setting = data[SIZE_REG_W-1:0];
            CFG_NUM_COLS:  cols_setting = data[SIZE_REG_W-1:0];
            CFG_LIFE_RULE: rule_setting = data[RULE_W-1:0];
            default: ;
        endcase
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_size();
        logic [CFG_DATA_W-1:0] v;
        v = $urandom;
        case ($urandom_range(0, 9))
            0:       v[SIZE_REG_W-1:0] = 0;
            1:       v[SIZE_REG_W-1:0] = $urandom_range(MAX_ROWS + 1, 127);
            2, 3:    v[SIZE_REG_W-1:0] = $urandom_range(9, MAX_ROWS);
            default: v[SIZE_REG_W-1:0] = $urandom_range(1, 8);
        endcase
        if ($urandom_range(0, 1) == 0)
            v[CFG_DATA_W-1:SIZE_REG_W] = '0;
        return v;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_rule();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return RST_LIFE_RULE;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_reset_values();
        send_item(OP_WRITE, 63, 63, 24'hFFFFFF);
        send_item(OP_WRITE, 0, 0, 24'h000000);
        eval_cell(0, 0);
        eval_cell(63, 63);
        eval_cell(0, 63);
    endtask

    task automatic test_size_limits();
        // zero sizes act as a single cell that neighbours itself
        write_reg(CFG_NUM_ROWS, '0);
        write_reg(CFG_NUM_COLS, '0);
        write_reg(CFG_LIFE_RULE, '1);
        send_item(OP_WRITE, 0, 0, 24'hFFFFFF);
        eval_cell(0, 0);
        send_item(OP_WRITE, 63, 0, 24'h123456);
        send_item(OP_EVAL, 0, 63, 24'hFFFFFF);
        send_item(OP_EVAL, 63, 63, 24'h000000);
        write_reg(CFG_LIFE_RULE, '0);
        eval_cell(0, 0);
        // blinker on a 3x3 torus
        write_reg(CFG_NUM_ROWS, 18'd3);
        write_reg(CFG_NUM_COLS, 18'd3);
        write_reg(CFG_LIFE_RULE, RST_LIFE_RULE);
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                send_item(OP_WRITE, r, c, (c == 1) ? 24'hFFFFFF : 24'h000000);
        eval_cell(1, 0);
        eval_cell(1, 1);
        eval_cell(0, 2);
        // oversized settings clamp to the frame
        write_reg(CFG_NUM_ROWS, 18'd65);
        write_reg(CFG_NUM_COLS, '1);
        eval_cell(63, 63);
        eval_cell(32, 0);
    endtask

    task automatic test_random_phases(input int quota);
        int base;
        int rows;
        int cols;
        int roll;
        base = items_sent;
        while (items_sent - base < quota)
        begin
            write_reg(CFG_NUM_ROWS, pick_size());
            write_reg(CFG_NUM_COLS, pick_size());
            write_reg(CFG_LIFE_RULE, pick_rule());
            if ($urandom_range(0, 4) == 0)
                write_reg(CFG_SPARE, $urandom);
            rows = used_extent(rows_setting, MAX_ROWS);
            cols = used_extent(cols_setting, MAX_COLS);
            repeat ($urandom_range(40, 160))
            begin
                roll = $urandom_range(0, 19);
                if (roll < 2)
                    send_item(OP_WRITE, $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
                else if (roll < 4)
                    eval_cell($urandom_range(0, 63), $urandom_range(0, 63));
                else if (roll < 11)
                    send_item(OP_WRITE, $urandom_range(0, rows - 1), $urandom_range(0, cols - 1),
                              $urandom);
                else
                    eval_cell($urandom_range(0, rows - 1), $urandom_range(0, cols - 1));
            end
        end
    endtask

    task automatic test_backpressure();
        write_reg(CFG_NUM_ROWS, 18'd4);
        write_reg(CFG_NUM_COLS, 18'd4);
        write_reg(CFG_LIFE_RULE, pick_rule());
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                if (!cell_known[r * MAX_COLS + c])
                    send_item(OP_WRITE, r, c, $urandom);
        hold_req = 1'b1;
        repeat (40) eval_cell($urandom_range(0, 3), $urandom_range(0, 3));
        settle();
    endtask

    task automatic test_steady_stream();
        idle_on = 1'b0;
        test_random_phases(250);
    endtask

    initial
    begin : result_drain
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                res_ch.ready <= 1'b1;
                hold_req = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                res_ch.ready <= 1'b1;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_check
        cell_result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with none pending: next_pixel %06h out_of_range %0b",
                       res_ch.next_pixel, res_ch.out_of_range);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (res_ch.next_pixel !== want.next_pixel)
                begin
                    $error("next_pixel: expected %06h actual %06h",
                           want.next_pixel, res_ch.next_pixel);
                    errors++;
                end
                if (res_ch.out_of_range !== want.out_of_range)
                begin
                    $error("out_of_range: expected %0b actual %0b",
                           want.out_of_range, res_ch.out_of_range);
                    errors++;
                end
            end
        end
    end

    initial
    begin : watchdog
        #10_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin : run
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= CFG_NUM_ROWS;
        cfg_data     <= '0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.op    <= OP_WRITE;
        cmd_ch.row   <= '0;
        cmd_ch.col   <= '0;
        cmd_ch.pixel <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_size_limits();
        test_random_phases(1500);
        test_backpressure();
        test_steady_stream();
        settle();
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

### files.f
+incdir+sv
sv/blcu_pkg.sv
sv/blcu_cmd_if.sv
sv/blcu_result_if.sv
sv/blcu_frame_mem.sv
sv/blcu_ctrl.sv
sv/blcu_rule_eval.sv
sv/bitplane_life_cell_update.sv
sv/blcu_checker.sv
dv/tb.sv
